// File: rtl/sine_cosine_table_interpolator_defines.svh
// ----------------------------------------------------------------------------
// Sine/cosine interpolator assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SINE_COSINE_TABLE_INTERPOLATOR_DEFINES_SVH
`define SINE_COSINE_TABLE_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define SCTI_ASSERT_IMPL(name, clk_sig, rstn_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (!(rstn_sig)) (ante) |-> (cons)) \
    else $error("scti assertion failed");
`define SCTI_ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (!(rstn_sig)) (ante) |=> (cons)) \
    else $error("scti assertion failed");
`else
`define SCTI_ASSERT_IMPL(name, clk_sig, rstn_sig, ante, cons)
`define SCTI_ASSERT_NEXT(name, clk_sig, rstn_sig, ante, cons)
`endif

`endif

// File: rtl/scti_pkg.sv
// ----------------------------------------------------------------------------
// scti_pkg
// Constants, beat types and the quarter-wave table function.
// ----------------------------------------------------------------------------
package scti_pkg;

  localparam int TABLE_POINTS = 21;
  localparam int RESULT_BITS  = 16;

  localparam int TABLE_SEGS = TABLE_POINTS - 1;
  localparam int IDX_W      = $clog2(TABLE_POINTS);
  localparam int SEGS_W     = $clog2(TABLE_SEGS + 1);
  localparam int FRAC_W     = 16;
  localparam int FRAC1_W    = FRAC_W + 1;
  localparam int POS_W      = $clog2(TABLE_SEGS) + FRAC_W + 1;
  localparam int IDXF_W     = POS_W - FRAC_W;

  localparam int ANGLE_W   = 16;
  localparam int SHIFT_Q24 = 12;
  localparam int X_W       = 29;
  localparam int ABS_W     = 28;
  localparam int TWO_W     = 27;
  localparam int PI_W      = 26;
  localparam int RED_W     = 25;

  localparam int PI_Q24      = 52707179;
  localparam int HALF_PI_Q24 = 26353589;
  localparam int TWO_PI_Q24  = 105414357;
  localparam int FOUR_PI_Q24 = 210828714;

  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 32;
  localparam logic [63:0] RECIP_WIDE =
    ((64'(TABLE_SEGS) * 64'd131072) << RECIP_SHIFT) / 64'(PI_Q24);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];
  localparam int MPROD_W = RED_W + RECIP_W;
  localparam int AK_W    = RED_W + SEGS_W + FRAC_W + 1;

  localparam int VAL_W       = 31;
  localparam int HALF_PI_Q30 = 1686629713;
  localparam int ONE_Q30     = 1073741824;
  localparam int IPROD_W     = VAL_W + FRAC1_W;

  localparam int MAG_W     = 32;
  localparam int RND_SHIFT = (RESULT_BITS >= 31) ? 0 : 31 - RESULT_BITS;
  localparam logic [MAG_W-1:0] RND_HALF =
    (RESULT_BITS >= 31) ? '0 : MAG_W'(64'd1 << (30 - RESULT_BITS));
  localparam int LSHIFT = (RESULT_BITS >= 32) ? 1 : 0;
  localparam logic [MAG_W-1:0] MAX_MAG = MAG_W'((64'd1 << (RESULT_BITS - 1)) - 64'd1);
  localparam logic [RESULT_BITS-1:0] RESULT_MIN = {1'b1, {(RESULT_BITS-1){1'b0}}};

  localparam int RR_STAGES = 5;
  localparam int PD_STAGES = 3;
  localparam int IP_STAGES = 5;

  typedef struct packed {
    logic             neg;
    logic [RED_W-1:0] ang;
  } red_t;

  typedef struct packed {
    logic             neg;
    logic [POS_W-1:0] pos;
  } pos_t;

  function automatic logic [VAL_W-1:0] sine_entry(input int k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    x    = (64'(k) * 64'(HALF_PI_Q30) + 64'(TABLE_SEGS / 2)) / 64'(TABLE_SEGS);
    x2   = (x * x) >> 30;
    term = x;
    acc  = signed'(x);
    for (int n = 1; n <= 9; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) == 1) begin
        acc = acc - signed'(term);
      end else begin
        acc = acc + signed'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > 64'sd1073741824) begin
      acc = 64'(ONE_Q30);
    end
    return VAL_W'(acc);
  endfunction

endpackage

// File: rtl/scti_if.sv
// ----------------------------------------------------------------------------
// scti_in_if / scti_out_if
// Valid/ready channels for angle beats and result beats.
// ----------------------------------------------------------------------------
interface scti_in_if;
  import scti_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [ANGLE_W-1:0] angle;
  modport source (output valid, output operation, output angle, input ready);
  modport sink (input valid, input operation, input angle, output ready);
endinterface

interface scti_out_if;
  import scti_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [RESULT_BITS-1:0] trig_value;
  modport source (output valid, output trig_value, input ready);
  modport sink (input valid, input trig_value, output ready);
endinterface

// File: rtl/sine_cosine_table_interpolator.sv
// ----------------------------------------------------------------------------
// sine_cosine_table_interpolator
// Pipeline: 5 range reduction, 3 table position divide and 5 interpolation
// register stages from input beat to result beat.
// Throughput: one beat per cycle while results are taken; a stalled result holds in the output
// register while empty stages behind it keep filling.
// Reset: synchronous, active low; clears stage valid bits only.
// ----------------------------------------------------------------------------
`include "sine_cosine_table_interpolator_defines.svh"

module sine_cosine_table_interpolator (
  input logic       clk,
  input logic       rst_n,
  scti_in_if.sink   in_chan,
  scti_out_if.source out_chan
);
  import scti_pkg::*;

  logic red_valid;
  logic red_ready;
  red_t red;
  logic pos_valid;
  logic pos_ready;
  pos_t pos;

  scti_range_reduce u_range (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_op     (in_chan.operation),
    .in_angle  (in_chan.angle),
    .out_valid (red_valid),
    .out_ready (red_ready),
    .out_red   (red)
  );

  scti_pos_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (red_valid),
    .in_ready  (red_ready),
    .in_red    (red),
    .out_valid (pos_valid),
    .out_ready (pos_ready),
    .out_pos   (pos)
  );

  scti_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pos_valid),
    .in_ready  (pos_ready),
    .in_pos    (pos),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_trig  (out_chan.trig_value)
  );

  `SCTI_ASSERT_IMPL(a_red_in_quarter, clk, rst_n, red_valid, red.ang <= RED_W'(HALF_PI_Q24))
  `SCTI_ASSERT_IMPL(a_pos_in_table, clk, rst_n, pos_valid, pos.pos < POS_W'(TABLE_SEGS << FRAC_W))
  `SCTI_ASSERT_IMPL(a_out_symmetric, clk, rst_n, out_chan.valid, out_chan.trig_value != RESULT_MIN)

endmodule

// File: rtl/scti_range_reduce.sv
// ----------------------------------------------------------------------------
// scti_range_reduce
// Folds the (optionally pi/2 offset) angle onto [0, pi/2] and tracks sign.
// ----------------------------------------------------------------------------
module scti_range_reduce (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic signed [scti_pkg::ANGLE_W-1:0] in_angle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output scti_pkg::red_t                      out_red
);
  import scti_pkg::*;

  logic [RR_STAGES-1:0] vld_r;
  logic [RR_STAGES-1:0] vld_nxt;
  logic [RR_STAGES:0]   adv;

  logic signed [X_W-1:0] x1_r, x1_nxt;
  logic                  neg2_r, neg2_nxt;
  logic [ABS_W-1:0]      a2_r, a2_nxt;
  logic                  neg3_r;
  logic [TWO_W-1:0]      a3_r, a3_nxt;
  logic                  neg4_r, neg4_nxt;
  logic [PI_W-1:0]       a4_r, a4_nxt;
  logic                  neg5_r;
  logic [RED_W-1:0]      a5_r, a5_nxt;

  always_comb begin
    adv[RR_STAGES] = out_ready;
    for (int k = RR_STAGES - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt = (adv[RR_STAGES-1:0] & {vld_r[RR_STAGES-2:0], in_valid}) |
              (~adv[RR_STAGES-1:0] & vld_r);
  end

  always_comb begin
    x1_nxt   = (X_W'(in_angle) <<< SHIFT_Q24) + (in_op ? X_W'(HALF_PI_Q24) : '0);
    neg2_nxt = x1_r[X_W-1];
    a2_nxt   = x1_r[X_W-1] ? ABS_W'(-x1_r) : ABS_W'(x1_r);
    if (a2_r > ABS_W'(FOUR_PI_Q24)) begin
      a3_nxt = TWO_W'(a2_r - ABS_W'(FOUR_PI_Q24));
    end else if (a2_r > ABS_W'(TWO_PI_Q24)) begin
      a3_nxt = TWO_W'(a2_r - ABS_W'(TWO_PI_Q24));
    end else begin
      a3_nxt = TWO_W'(a2_r);
    end
    if (a3_r > TWO_W'(PI_Q24)) begin
      a4_nxt   = PI_W'(a3_r - TWO_W'(PI_Q24));
      neg4_nxt = !neg3_r;
    end else begin
      a4_nxt   = PI_W'(a3_r);
      neg4_nxt = neg3_r;
    end
    if (a4_r > PI_W'(HALF_PI_Q24)) begin
      a5_nxt = RED_W'(PI_W'(PI_Q24) - a4_r);
    end else begin
      a5_nxt = RED_W'(a4_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x1_r <= x1_nxt;
    end
    if (adv[1]) begin
      neg2_r <= neg2_nxt;
      a2_r   <= a2_nxt;
    end
    if (adv[2]) begin
      neg3_r <= neg2_r;
      a3_r   <= a3_nxt;
    end
    if (adv[3]) begin
      neg4_r <= neg4_nxt;
      a4_r   <= a4_nxt;
    end
    if (adv[4]) begin
      neg5_r <= neg4_r;
      a5_r   <= a5_nxt;
    end
  end

  assign in_ready    = adv[0];
  assign out_valid   = vld_r[RR_STAGES-1];
  assign out_red.neg = neg5_r;
  assign out_red.ang = a5_r;

endmodule

// File: rtl/scti_pos_div.sv
// ----------------------------------------------------------------------------
// scti_pos_div
// Table position: angle * 2 * segments * 65536 / pi by reciprocal multiply
// and a one-step remainder correction.
// ----------------------------------------------------------------------------
module scti_pos_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  scti_pkg::red_t in_red,
  output logic           out_valid,
  input  logic           out_ready,
  output scti_pkg::pos_t out_pos
);
  import scti_pkg::*;

  logic [PD_STAGES-1:0] vld_r;
  logic [PD_STAGES-1:0] vld_nxt;
  logic [PD_STAGES:0]   adv;

  logic [MPROD_W-1:0] mprod;
  logic [AK_W-1:0]    rem;

  logic             neg1_r;
  logic [RED_W-1:0] a1_r;
  logic [POS_W-1:0] q1_r, q1_nxt;
  logic             neg2_r;
  logic [POS_W-1:0] q2_r;
  logic [AK_W-1:0]  qp2_r, qp2_nxt;
  logic [AK_W-1:0]  ak2_r, ak2_nxt;
  logic             neg3_r;
  logic [POS_W-1:0] pos3_r, pos3_nxt;

  always_comb begin
    adv[PD_STAGES] = out_ready;
    for (int k = PD_STAGES - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt = (adv[PD_STAGES-1:0] & {vld_r[PD_STAGES-2:0], in_valid}) |
              (~adv[PD_STAGES-1:0] & vld_r);
  end

  always_comb begin
    mprod    = MPROD_W'(in_red.ang) * MPROD_W'(RECIP);
    q1_nxt   = mprod[RECIP_SHIFT +: POS_W];
    qp2_nxt  = AK_W'(q1_r) * AK_W'(PI_Q24);
    ak2_nxt  = (AK_W'(a1_r) * AK_W'(TABLE_SEGS)) << (FRAC_W + 1);
    rem      = ak2_r - qp2_r;
    pos3_nxt = (rem >= AK_W'(PI_Q24)) ? POS_W'(q2_r + 1'b1) : q2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      neg1_r <= in_red.neg;
      a1_r   <= in_red.ang;
      q1_r   <= q1_nxt;
    end
    if (adv[1]) begin
      neg2_r <= neg1_r;
      q2_r   <= q1_r;
      qp2_r  <= qp2_nxt;
      ak2_r  <= ak2_nxt;
    end
    if (adv[2]) begin
      neg3_r <= neg2_r;
      pos3_r <= pos3_nxt;
    end
  end

  assign in_ready    = adv[0];
  assign out_valid   = vld_r[PD_STAGES-1];
  assign out_pos.neg = neg3_r;
  assign out_pos.pos = pos3_r;

endmodule

// File: rtl/scti_interp.sv
// ----------------------------------------------------------------------------
// scti_interp
// Quarter-wave table read, linear interpolation, rounding, saturation, sign.
// ----------------------------------------------------------------------------
module scti_interp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  scti_pkg::pos_t                          in_pos,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [scti_pkg::RESULT_BITS-1:0] out_trig
);
  import scti_pkg::*;

  logic [IP_STAGES-1:0] vld_r;
  logic [IP_STAGES-1:0] vld_nxt;
  logic [IP_STAGES:0]   adv;

  logic [VAL_W-1:0] sin_tbl [TABLE_POINTS];

  for (genvar k = 0; k < TABLE_POINTS; k++) begin : g_tbl
    localparam logic [VAL_W-1:0] ENTRY = sine_entry(k);
    assign sin_tbl[k] = ENTRY;
  end

  logic [IDXF_W-1:0]  idxf;
  logic [VAL_W-1:0]   lo, hi;
  logic [IPROD_W-1:0] iprod;
  logic [MAG_W-1:0]   sum;
  logic [MAG_W-1:0]   sat;

  logic                   neg1_r;
  logic [IDX_W-1:0]       idx1_r, idx1_nxt;
  logic [FRAC1_W-1:0]     frac1_r, frac1_nxt;
  logic                   neg2_r;
  logic [FRAC1_W-1:0]     frac2_r;
  logic [VAL_W-1:0]       lo2_r;
  logic [VAL_W-1:0]       diff2_r, diff2_nxt;
  logic                   neg3_r;
  logic [MAG_W-1:0]       loh3_r, loh3_nxt;
  logic [VAL_W-1:0]       ip3_r, ip3_nxt;
  logic                   neg4_r;
  logic [MAG_W-1:0]       mag4_r, mag4_nxt;
  logic [RESULT_BITS-1:0] res5_r, res5_nxt;

  always_comb begin
    adv[IP_STAGES] = out_ready;
    for (int k = IP_STAGES - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt = (adv[IP_STAGES-1:0] & {vld_r[IP_STAGES-2:0], in_valid}) |
              (~adv[IP_STAGES-1:0] & vld_r);
  end

  always_comb begin
    idxf = in_pos.pos[POS_W-1:FRAC_W];
    // clamp at the end of the table: last interval, full fraction
    if (idxf >= IDXF_W'(TABLE_SEGS)) begin
      idx1_nxt  = IDX_W'(TABLE_SEGS - 1);
      frac1_nxt = FRAC1_W'(1 << FRAC_W);
    end else begin
      idx1_nxt  = IDX_W'(idxf);
      frac1_nxt = {1'b0, in_pos.pos[FRAC_W-1:0]};
    end
    lo        = sin_tbl[idx1_r];
    hi        = sin_tbl[IDX_W'(idx1_r + 1'b1)];
    diff2_nxt = (hi > lo) ? VAL_W'(hi - lo) : '0;
    iprod     = IPROD_W'(diff2_r) * IPROD_W'(frac2_r);
    ip3_nxt   = iprod[FRAC_W +: VAL_W];
    loh3_nxt  = MAG_W'(lo2_r) + RND_HALF;
    sum       = loh3_r + MAG_W'(ip3_r);
    mag4_nxt  = (sum >> RND_SHIFT) << LSHIFT;
    sat       = (mag4_r > MAX_MAG) ? MAX_MAG : mag4_r;
    res5_nxt  = neg4_r ? RESULT_BITS'(-sat) : RESULT_BITS'(sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      neg1_r  <= in_pos.neg;
      idx1_r  <= idx1_nxt;
      frac1_r <= frac1_nxt;
    end
    if (adv[1]) begin
      neg2_r  <= neg1_r;
      frac2_r <= frac1_r;
      lo2_r   <= lo;
      diff2_r <= diff2_nxt;
    end
    if (adv[2]) begin
      neg3_r <= neg2_r;
      loh3_r <= loh3_nxt;
      ip3_r  <= ip3_nxt;
    end
    if (adv[3]) begin
      neg4_r <= neg3_r;
      mag4_r <= mag4_nxt;
    end
    if (adv[4]) begin
      res5_r <= res5_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[IP_STAGES-1];
  assign out_trig  = signed'(res5_r);

endmodule

// File: tb/tb_sine_cosine_table_interpolator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sine_cosine_table_interpolator
// Drives sine and cosine requests through the valid/ready angle channel with
// random gaps and output back-pressure, predicts every result with an
// independent quarter-wave table interpolator and compares each result beat
// in order against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_sine_cosine_table_interpolator;
  import scti_pkg::*;

  localparam int  RANDOM_ANGLES = 1000;
  localparam int  CYCLE_LIMIT   = 600000;
  localparam bit  OP_SINE       = 1'b0;
  localparam bit  OP_COSINE     = 1'b1;

  class trig_scoreboard;
    bit [63:0]                   quarter_wave[TABLE_POINTS];
    logic [RESULT_BITS-1:0]      pending_trig[$];
    int                          errors;

    function new();
      bit [63:0]      x;
      bit [63:0]      x2;
      bit [63:0]      term;
      longint         acc;
      longint unsigned segs;
      segs   = 64'(TABLE_POINTS - 1);
      errors = 0;
      for (int k = 0; k < TABLE_POINTS; k++) begin
        x    = (64'(k) * 64'd1686629713 + segs / 2) / segs;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 9; n++) begin
          term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
          acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > 64'sd1073741824) acc = 64'sd1073741824;
        quarter_wave[k] = 64'(acc);
      end
    endfunction

    function logic [RESULT_BITS-1:0] interpolate_trig(bit op, logic signed [ANGLE_W-1:0] ang);
      longint          x;
      longint          a;
      bit              neg;
      bit [63:0]       pos;
      bit [63:0]       idx;
      bit [63:0]       frac;
      bit [63:0]       lo;
      bit [63:0]       hi;
      bit [63:0]       diff;
      bit [63:0]       v30;
      bit [63:0]       mag;
      bit [63:0]       max_mag;
      int              sh;
      x = longint'(ang) * 4096;
      if (op == OP_COSINE) x = x + 64'sd26353589;
      neg = (x < 0);
      a   = neg ? -x : x;
      if (a > 64'sd105414357) a = a - 64'sd105414357;
      if (a > 64'sd105414357) a = a - 64'sd105414357;
      if (a > 64'sd52707179) begin
        a   = a - 64'sd52707179;
        neg = !neg;
      end
      if (a > 64'sd26353589) a = 64'sd52707179 - a;
      pos  = (64'(a) * 64'(2 * (TABLE_POINTS - 1)) * 64'd65536) / 64'd52707179;
      idx  = pos >> 16;
      frac = pos & 64'hFFFF;
      if (idx >= 64'(TABLE_POINTS - 1)) begin
        idx  = 64'(TABLE_POINTS - 2);
        frac = 64'd65536;
      end
      lo   = quarter_wave[idx];
      hi   = quarter_wave[idx + 1];
      diff = (hi > lo) ? hi - lo : 64'd0;
      v30  = lo + ((diff * frac) >> 16);
      if (RESULT_BITS >= 32) begin
        mag = v30 << 1;
      end else begin
        sh  = 31 - RESULT_BITS;
        mag = (sh == 0) ? v30 : (v30 + (64'd1 << (sh - 1))) >> sh;
      end
      max_mag = (64'd1 << (RESULT_BITS - 1)) - 64'd1;
      if (mag > max_mag) mag = max_mag;
      return neg ? RESULT_BITS'(64'd0 - mag) : RESULT_BITS'(mag);
    endfunction

    function void note_angle(bit op, logic signed [ANGLE_W-1:0] ang);
      pending_trig.push_back(interpolate_trig(op, ang));
    endfunction

    function void check_trig(logic [RESULT_BITS-1:0] actual);
      logic [RESULT_BITS-1:0] expected;
      if (pending_trig.size() == 0) begin
        $error("trig_value: unexpected beat, actual %0d", $signed(actual));
        errors++;
        return;
      end
      expected = pending_trig.pop_front();
      if (actual !== expected) begin
        $error("trig_value: expected %0d, actual %0d", $signed(expected), $signed(actual));
        errors++;
      end
    endfunction

    function int pending();
      return pending_trig.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   steady;
  int   cycle_count;

  trig_scoreboard sb = new();

  scti_in_if  in_if();
  scti_out_if out_if();

  sine_cosine_table_interpolator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_angle(bit op, logic signed [ANGLE_W-1:0] ang);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid     <= 1'b0;
      in_if.operation <= 1'($urandom);
      in_if.angle     <= ANGLE_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.angle     <= ang;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // score beats on the edge where they are accepted
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_angle(in_if.operation, in_if.angle);
      if (out_if.valid && out_if.ready) sb.check_trig(out_if.trig_value);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_sine_cosine_table_interpolator: FAIL");
      $finish;
    end
  end

  // result back-pressure: runs of ready, broken by short and occasional long stalls
  initial begin
    int  hold;
    bit  level;
    hold  = 0;
    level = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold == 0) begin
        level = steady || ($urandom_range(0, 3) != 0);
        if (level) hold = $urandom_range(1, 30);
        else hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      out_if.ready <= level;
      hold--;
      @(posedge clk);
    end
  end

  initial begin
    logic signed [ANGLE_W-1:0] edge_angles[12];
    logic signed [ANGLE_W-1:0] ang;
    int                        quadrant;
    cycle_count = 0;
    steady      = 1'b0;
    edge_angles = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 16'sd6433,
                    16'sd6434, 16'sd12867, 16'sd12868, 16'sd25735, 16'sd25736, -16'sd6434};
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.operation <= OP_SINE;
    in_if.angle     <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (edge_angles[i]) begin
      send_angle(OP_SINE, edge_angles[i]);
      send_angle(OP_COSINE, edge_angles[i]);
    end

    for (int i = 0; i < RANDOM_ANGLES; i++) begin
      steady = ((i / 150) % 4 == 3);
      if ($urandom_range(0, 3) == 0) begin
        // land near a multiple of pi/2, where reduction and table end matter
        quadrant = int'($urandom_range(0, 10)) - 5;
        ang      = ANGLE_W'(quadrant * 6434 + $urandom_range(0, 8) - 4);
      end else begin
        ang = ANGLE_W'($urandom);
      end
      send_angle(1'($urandom), ang);
    end
    in_if.valid <= 1'b0;
    @(posedge clk);

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_sine_cosine_table_interpolator: PASS");
    end else begin
      $display("tb_sine_cosine_table_interpolator: FAIL");
    end
    $finish;
  end

endmodule
